@@ src/siph_pkg.sv @@
`timescale 1ns / 1ps

package siph_pkg;

    // Field widths of the channels.
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned INDEX_W = 1;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [INDEX_W-1:0] index_t;

    // Register indexes of the configuration port.
    localparam index_t REG_KEY_LOW  = 1'b0;
    localparam index_t REG_KEY_HIGH = 1'b1;

    // Initialization constants and the default (self-test) key.
    localparam word_t MAGIC_A        = 64'h736F6D6570736575;
    localparam word_t MAGIC_B        = 64'h646F72616E646F6D;
    localparam word_t MAGIC_C        = 64'h6C7967656E657261;
    localparam word_t MAGIC_D        = 64'h7465646279746573;
    localparam word_t KEY_LOW_RESET  = 64'h0706050403020100;
    localparam word_t KEY_HIGH_RESET = 64'h0F0E0D0C0B0A0908;
    localparam word_t FIN_MASK       = 64'h00000000000000FF;

    localparam count_t FULL_COUNT = 4'd8;
    localparam len_t   BLOCK_LEN  = 8'd8;

    // The four state words.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } sip_state_t;

    // Sequencer steps.
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_R1   = 3'd1;
    localparam step_t STEP_R2   = 3'd2;
    localparam step_t STEP_F0   = 3'd3;
    localparam step_t STEP_F1   = 3'd4;
    localparam step_t STEP_F2   = 3'd5;
    localparam step_t STEP_F3   = 3'd6;
    localparam step_t STEP_EMIT = 3'd7;

    // Jump kinds of a control word.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_TAKE,
        JMP_BLOCK,
        JMP_EMIT
    } jmp_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic  rnd;
        logic  mix_in;
        logic  mix_out;
        logic  fin_c;
        logic  take;
        logic  emit;
        jmp_t  jmp;
        step_t target;
    } ctrl_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic rnd;
        logic mix_in;
        logic mix_out;
        logic fin_c;
        logic accept;
        logic load_tail;
        logic emit;
    } dp_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic last;
        logic mtail;
        logic out_free;
    } dp_status_t;

    // Microprogram: absorb takes two rounds, finalization four, then the result.
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = '{rnd: 1'b0, mix_in: 1'b0, mix_out: 1'b0, fin_c: 1'b0, take: 1'b0,
              emit: 1'b0, jmp: JMP_NEXT, target: STEP_IDLE};
        unique case (s)
            STEP_IDLE:
            begin
                w.take   = 1'b1;
                w.jmp    = JMP_TAKE;
                w.target = STEP_R1;
            end
            STEP_R1:
            begin
                w.rnd    = 1'b1;
                w.mix_in = 1'b1;
            end
            STEP_R2:
            begin
                w.rnd     = 1'b1;
                w.mix_out = 1'b1;
                w.take    = 1'b1;
                w.jmp     = JMP_BLOCK;
                w.target  = STEP_R1;
            end
            STEP_F0:
            begin
                w.rnd   = 1'b1;
                w.fin_c = 1'b1;
            end
            STEP_F1, STEP_F2, STEP_F3:
            begin
                w.rnd = 1'b1;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jmp    = JMP_EMIT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // One SipRound.
    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t r;
        r   = s;
        r.a = r.a + r.b;
        r.b = rotl(r.b, 13) ^ r.a;
        r.a = rotl(r.a, 32);
        r.c = r.c + r.d;
        r.d = rotl(r.d, 16) ^ r.c;
        r.a = r.a + r.d;
        r.d = rotl(r.d, 21) ^ r.a;
        r.c = r.c + r.b;
        r.b = rotl(r.b, 17) ^ r.c;
        r.c = rotl(r.c, 32);
        return r;
    endfunction

    // Tail word: valid bytes low, message length in the top byte.
    function automatic word_t tail_word(input word_t data, input count_t cnt, input len_t len);
        word_t t;
        t = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < int'(cnt))
            begin
                t[8*i +: 8] = data[8*i +: 8];
            end
        end
        t[WORD_W-1 -: LEN_W] = len;
        return t;
    endfunction

endpackage

@@ src/siph_if.sv @@
`timescale 1ns / 1ps

// Message word channel.
interface siph_msg_if
    import siph_pkg::*;
();
    logic   valid;
    logic   ready;
    word_t  data_word;
    count_t byte_count;
    logic   last_item;

    modport source (output valid, data_word, byte_count, last_item, input ready);
    modport sink   (input valid, data_word, byte_count, last_item, output ready);
endinterface

// Hash result channel.
interface siph_hash_if
    import siph_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

// Configuration write channel.
interface siph_cfg_if
    import siph_pkg::*;
();
    logic   valid;
    logic   ready;
    index_t index;
    word_t  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/siph_sequencer.sv @@
`timescale 1ns / 1ps

module siph_sequencer
    import siph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  dp_status_t st,
    output dp_ctrl_t   ctl
);

    step_t step_reg;
    step_t step_next;
    ctrl_t cw;
    logic  tail_turn;
    logic  accept;

    // Control word fetch and handshake qualification.
    always_comb
    begin
        cw        = ucode(step_reg);
        tail_turn = (cw.jmp == JMP_BLOCK) && st.last;
        msg_ready = cw.take && !tail_turn;
        accept    = msg_valid && msg_ready;
    end

    // Next step from the jump kind.
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.jmp)
            JMP_NEXT:
            begin
                step_next = step_reg + 3'd1;
            end
            JMP_TAKE:
            begin
                step_next = accept ? cw.target : step_reg;
            end
            JMP_BLOCK:
            begin
                priority if (!st.last)
                begin
                    step_next = accept ? cw.target : STEP_IDLE;
                end
                else if (!st.mtail)
                begin
                    step_next = cw.target;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            JMP_EMIT:
            begin
                step_next = st.out_free ? cw.target : step_reg;
            end
        endcase
    end

    // Strobes to the datapath.
    always_comb
    begin
        ctl.rnd       = cw.rnd;
        ctl.mix_in    = cw.mix_in;
        ctl.mix_out   = cw.mix_out;
        ctl.fin_c     = cw.fin_c;
        ctl.accept    = accept;
        ctl.load_tail = tail_turn && !st.mtail;
        ctl.emit      = cw.emit && st.out_free;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ src/siph_datapath.sv @@
`timescale 1ns / 1ps

module siph_datapath
    import siph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_ctrl_t   ctl,
    input  word_t      data_word,
    input  count_t     byte_count,
    input  logic       last_item,
    input  logic       cfg_we,
    input  index_t     cfg_index,
    input  word_t      cfg_data,
    input  logic       out_ready,
    output dp_status_t st,
    output word_t      hash_value,
    output logic       out_valid
);

    word_t      key_low_reg;
    word_t      key_high_reg;
    sip_state_t v_reg;
    sip_state_t v_next;
    word_t      m_reg;
    word_t      m_next;
    len_t       len_reg;
    len_t       len_next;
    logic       busy_reg;
    logic       last_reg;
    logic       mtail_reg;
    word_t      hash_reg;
    logic       out_valid_reg;
    sip_state_t rin;
    sip_state_t rout;
    count_t     cnt_sat;
    logic       full;
    len_t       len_base;

    // Status to the sequencer.
    always_comb
    begin
        st.last     = last_reg;
        st.mtail    = mtail_reg;
        st.out_free = !out_valid_reg || out_ready;
    end

    // Round unit with message injection and finalization constant.
    always_comb
    begin
        rin   = v_reg;
        if (ctl.fin_c)
        begin
            rin.c = v_reg.c ^ FIN_MASK;
        end
        if (ctl.mix_in)
        begin
            rin.d = v_reg.d ^ m_reg;
        end
        rout = sip_round(rin);
        if (ctl.mix_out)
        begin
            rout.a = rout.a ^ m_reg;
        end
    end

    // Incoming item: count, length and message word.
    always_comb
    begin
        cnt_sat  = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
        full     = !last_item || (cnt_sat == FULL_COUNT);
        len_base = busy_reg ? len_reg : '0;
        len_next = len_base + (full ? BLOCK_LEN : len_t'(cnt_sat));
        m_next   = full ? data_word : tail_word(data_word, cnt_sat, len_next);
    end

    // State words: key load at the first item of a message, else one round when the round strobe is set.
    always_comb
    begin
        v_next = v_reg;
        if (ctl.accept && !busy_reg)
        begin
            v_next.a = key_low_reg ^ MAGIC_A;
            v_next.b = key_high_reg ^ MAGIC_B;
            v_next.c = key_low_reg ^ MAGIC_C;
            v_next.d = key_high_reg ^ MAGIC_D;
        end
        else if (ctl.rnd)
        begin
            v_next = rout;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (ctl.accept)
        begin
            m_reg <= m_next;
        end
        else if (ctl.load_tail)
        begin
            m_reg <= tail_word('0, '0, len_reg);
        end
        if (ctl.emit)
        begin
            hash_reg <= v_reg.a ^ v_reg.b ^ v_reg.c ^ v_reg.d;
        end
    end

    // Message tracking and key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RESET;
            key_high_reg <= KEY_HIGH_RESET;
            len_reg      <= '0;
            busy_reg     <= 1'b0;
            last_reg     <= 1'b0;
            mtail_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                endcase
            end
            if (ctl.accept)
            begin
                len_reg   <= len_next;
                busy_reg  <= 1'b1;
                last_reg  <= last_item;
                mtail_reg <= last_item && !full;
            end
            else if (ctl.load_tail)
            begin
                mtail_reg <= 1'b1;
            end
            else if (ctl.emit)
            begin
                len_reg   <= '0;
                busy_reg  <= 1'b0;
                last_reg  <= 1'b0;
                mtail_reg <= 1'b0;
            end
        end
    end

    // Output register; a waiting result does not block the input side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign hash_value = hash_reg;
    assign out_valid  = out_valid_reg;

endmodule

@@ src/siphash24_mac_core.sv @@
`timescale 1ns / 1ps

// Channel | Role  | Payload
// msg     | sink  | data_word[63:0], byte_count[3:0], last_item
// hash    | source| hash_value[63:0]
// cfg     | sink  | index[0] (0 key_low, 1 key_high), data[63:0]
//
// A full block runs two rounds; the next word is taken during its second round.
// The last word of a message is followed by the finalization rounds and the
// result (after an extra length-only block when it holds 8 bytes); the single
// SipRound unit runs one round per cycle.
// Reset loads the default key; the state words are loaded from the key at the
// first word of each message. A stalled result waits in the output register.

module siphash24_mac_core
    import siph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    siph_msg_if.sink    msg,
    siph_hash_if.source hash,
    siph_cfg_if.sink    cfg
);

    dp_ctrl_t   ctl;
    dp_status_t st;

    // Keys are plain registers, so writes are always taken.
    assign cfg.ready = 1'b1;

    siph_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_ready (msg.ready),
        .st        (st),
        .ctl       (ctl)
    );

    siph_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .data_word  (msg.data_word),
        .byte_count (msg.byte_count),
        .last_item  (msg.last_item),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_ready  (hash.ready),
        .st         (st),
        .hash_value (hash.hash_value),
        .out_valid  (hash.valid)
    );

endmodule

@@ tb/siphash24_mac_core_tb.sv @@
`timescale 1ns / 1ps

// Tracks the keyed hash state of the block and holds the hash values that are
// still owed by it.
class mac_tracker;
    siph_pkg::word_t key_lo;
    siph_pkg::word_t key_hi;
    siph_pkg::word_t va;
    siph_pkg::word_t vb;
    siph_pkg::word_t vc;
    siph_pkg::word_t vd;
    siph_pkg::len_t  msg_len;
    bit              in_msg;
    siph_pkg::word_t owed_hashes[$];
    int              errors;
    int              hashes_seen;

    function new();
        key_lo  = siph_pkg::KEY_LOW_RESET;
        key_hi  = siph_pkg::KEY_HIGH_RESET;
        errors  = 0;
        hashes_seen = 0;
        reload();
    endfunction

    // Start a fresh message from the current key.
    function void reload();
        va      = key_lo ^ siph_pkg::MAGIC_A;
        vb      = key_hi ^ siph_pkg::MAGIC_B;
        vc      = key_lo ^ siph_pkg::MAGIC_C;
        vd      = key_hi ^ siph_pkg::MAGIC_D;
        msg_len = '0;
        in_msg  = 1'b0;
    endfunction

    function siph_pkg::word_t rol(siph_pkg::word_t x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    // One ARX round over the four state words.
    function void mix_round();
        va = va + vb;
        vb = rol(vb, 13) ^ va;
        va = rol(va, 32);
        vc = vc + vd;
        vd = rol(vd, 16) ^ vc;
        va = va + vd;
        vd = rol(vd, 21) ^ va;
        vc = vc + vb;
        vb = rol(vb, 17) ^ vc;
        vc = rol(vc, 32);
    endfunction

    function void absorb_block(siph_pkg::word_t m);
        vd = vd ^ m;
        mix_round();
        mix_round();
        va = va ^ m;
    endfunction

    function void write_key(siph_pkg::index_t idx, siph_pkg::word_t value);
        if (idx == siph_pkg::REG_KEY_LOW)
        begin
            key_lo = value;
        end
        else
        begin
            key_hi = value;
        end
    endfunction

    // Called for every accepted message word; a last word yields one hash.
    function void note_word(siph_pkg::word_t data, siph_pkg::count_t cnt, logic last);
        int              nbytes;
        siph_pkg::word_t tail;
        if (!in_msg)
        begin
            reload();
            in_msg = 1'b1;
        end
        if (!last)
        begin
            absorb_block(data);
            msg_len = msg_len + siph_pkg::BLOCK_LEN;
            return;
        end
        nbytes = (cnt >= siph_pkg::FULL_COUNT) ? 8 : int'(cnt);
        if (nbytes == 8)
        begin
            absorb_block(data);
            msg_len = msg_len + siph_pkg::BLOCK_LEN;
            nbytes  = 0;
        end
        msg_len = msg_len + siph_pkg::len_t'(nbytes);
        tail = '0;
        for (int i = 0; i < nbytes; i++)
        begin
            tail[8*i +: 8] = data[8*i +: 8];
        end
        tail[63:56] = msg_len;
        absorb_block(tail);
        vc = vc ^ siph_pkg::FIN_MASK;
        repeat (4) mix_round();
        owed_hashes.push_back(va ^ vb ^ vc ^ vd);
        reload();
    endfunction

    // Called for every accepted hash transfer.
    function void check_hash(siph_pkg::word_t got);
        siph_pkg::word_t want;
        hashes_seen++;
        if (owed_hashes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: hash %h arrived with none outstanding", got);
            end
            return;
        end
        want = owed_hashes.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: hash_value expected %h, got %h", want, got);
            end
        end
    endfunction
endclass

module siphash24_mac_core_tb;
    import siph_pkg::*;

    localparam int PHASE_WORDS = 200;
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n;

    siph_msg_if  msg_ch ();
    siph_hash_if hash_ch ();
    siph_cfg_if  cfg_ch ();

    siphash24_mac_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .hash  (hash_ch),
        .cfg   (cfg_ch)
    );

    mac_tracker tracker = new();

    int gap_pct = 33;
    int words_sent = 0;
    int msgs_sent = 0;
    int key_settings = 1;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch every channel for transfers and keep the tracker in step.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                tracker.write_key(cfg_ch.index, cfg_ch.data);
            end
            if (msg_ch.valid && msg_ch.ready)
            begin
                tracker.note_word(msg_ch.data_word, msg_ch.byte_count, msg_ch.last_item);
            end
            if (hash_ch.valid && hash_ch.ready)
            begin
                tracker.check_hash(hash_ch.hash_value);
            end
        end
    end

    // Result side backpressure.
    initial
    begin
        hash_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hash_ch.ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Offer one message word and hold it until it is taken.
    task automatic send_word(input word_t data, input count_t cnt, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_word  <= data;
        msg_ch.byte_count <= cnt;
        msg_ch.last_item  <= last;
        @(posedge clk);
        while (!msg_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (last)
        begin
            msgs_sent++;
        end
    endtask

    task automatic write_reg(input index_t idx, input word_t value);
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every owed hash has been delivered and the core has settled.
    task automatic drain();
        while (tracker.owed_hashes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The message channel goes quiet before the key changes, so that the last
    // word is not offered again while the core finishes.
    task automatic set_key(input word_t lo, input word_t hi);
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        drain();
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        key_settings++;
    endtask

    // A message of full blocks with random content and a random tail.
    task automatic send_message(input int nblocks);
        count_t cnt;
        for (int i = 0; i < nblocks; i++)
        begin
            cnt = ($urandom_range(99) < 85) ? FULL_COUNT : count_t'($urandom_range(15));
            send_word({$urandom(), $urandom()}, cnt, 1'b0);
        end
        cnt = ($urandom_range(99) < 80) ? count_t'($urandom_range(8))
                                         : count_t'($urandom_range(15, 9));
        send_word({$urandom(), $urandom()}, cnt, 1'b1);
    endtask

    // Random traffic; the first message is long enough to wrap the length byte.
    task automatic random_phase();
        int start;
        int pick;
        start = words_sent;
        send_message($urandom_range(40, 32));
        while (words_sent - start < PHASE_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                send_message($urandom_range(4));
            end
            else if (pick < 95)
            begin
                send_message($urandom_range(12, 5));
            end
            else
            begin
                send_message($urandom_range(40, 31));
            end
        end
    endtask

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence.
    initial
    begin
        msg_ch.valid      = 1'b0;
        msg_ch.data_word  = '0;
        msg_ch.byte_count = '0;
        msg_ch.last_item  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_KEY_LOW;
        cfg_ch.data       = '0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the default key.
        send_word('1, 4'd0, 1'b1);
        send_word(64'h0706050403020100, FULL_COUNT, 1'b0);
        send_word(64'h000E0D0C0B0A0908, 4'd7, 1'b1);
        send_word('1, FULL_COUNT, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_word(64'h0123456789ABCDEF, 4'd0, 1'b0);
        send_word(64'hFEDCBA9876543210, 4'd3, 1'b1);
        send_word('0, 4'd15, 1'b0);
        send_word('1, 4'd1, 1'b1);
        for (int n = 1; n < 8; n++)
        begin
            send_word('1, count_t'(n), 1'b1);
        end
        send_word('0, 4'd9, 1'b1);

        // Random traffic under several keys, the extremes among them.
        set_key('0, '0);
        random_phase();
        set_key('1, '1);
        gap_pct = 0;
        random_phase();
        gap_pct = 33;
        set_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
        random_phase();
        set_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
        random_phase();

        @(negedge clk);
        msg_ch.valid <= 1'b0;
        drain();

        $display("Sent %0d message words in %0d messages under %0d keys.",
                 words_sent, msgs_sent, key_settings);
        $display("Checked %0d hash values; %0d errors, %0d hashes never delivered.",
                 tracker.hashes_seen, tracker.errors, tracker.owed_hashes.size());
        if (tracker.errors == 0 && tracker.owed_hashes.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
